// ===== sv/tsgm_pkg.sv =====
// ----------------------------------------------------------------------------
// tsgm_pkg
// Shared types and constants of the timestamp group median merge block.
// ----------------------------------------------------------------------------
package tsgm_pkg;

  localparam int unsigned MAX_GROUP  = 64;
  localparam int unsigned PRICE_BITS = 32;

  localparam int unsigned IDX_W  = $clog2(MAX_GROUP);
  localparam int unsigned CNT_W  = $clog2(MAX_GROUP + 1);
  localparam int unsigned GCNT_W = 7;
  localparam int unsigned SYM_W  = 16;
  localparam int unsigned DATE_W = 27;
  localparam int unsigned TIME_W = 27;
  localparam int unsigned MODE_W = 8;

  typedef logic [PRICE_BITS-1:0] price_t;
  typedef logic [IDX_W-1:0]      idx_t;
  typedef logic [CNT_W-1:0]      cnt_t;

  typedef struct packed {
    logic              end_marker;
    logic [SYM_W-1:0]  symbol_code;
    logic [DATE_W-1:0] quote_date;
    logic [TIME_W-1:0] time_of_day;
    price_t            bid_price;
    price_t            offer_price;
    logic [MODE_W-1:0] quote_mode;
  } in_item_t;

  typedef struct packed {
    logic [SYM_W-1:0]  out_symbol;
    logic [DATE_W-1:0] out_date;
    logic [TIME_W-1:0] out_time;
    price_t            median_bid;
    price_t            median_offer;
    logic [MODE_W-1:0] out_mode;
    logic [GCNT_W-1:0] group_count;
    logic              overflow_flag;
  } out_item_t;

  // Insertion control shared by both price chains.
  typedef struct packed {
    logic ins;    // write one price into the chain this cycle
    cnt_t count;  // number of entries already held before the write
  } chain_ctrl_t;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_MEDIAN
  } tsgm_state_e;

endpackage

// ===== sv/tsgm_cell.sv =====
// ----------------------------------------------------------------------------
// tsgm_cell
// One entry of an ascending price chain with in-place sorted insertion.
// ----------------------------------------------------------------------------
module tsgm_cell (
  input  logic                  clk_i,
  input  tsgm_pkg::idx_t        idx_i,
  input  tsgm_pkg::chain_ctrl_t ctrl_i,
  input  tsgm_pkg::price_t      val_i,
  input  logic                  left_gt_i,
  input  tsgm_pkg::price_t      left_val_i,
  output logic                  gt_o,
  output tsgm_pkg::price_t      val_o
);

  tsgm_pkg::price_t store_q, store_d;
  logic             held;
  logic             at_end;

  assign held   = {1'b0, idx_i} < ctrl_i.count;
  assign at_end = {1'b0, idx_i} == ctrl_i.count;
  assign gt_o   = held && (store_q > val_i);
  assign val_o  = store_q;

  // Shift right when the new price belongs to the left; else take it here.
  always_comb begin
    store_d = store_q;
    if (ctrl_i.ins && (gt_o || at_end)) begin
      store_d = left_gt_i ? left_val_i : val_i;
    end
  end

  always_ff @(posedge clk_i) begin
    store_q <= store_d;
  end

endmodule

// ===== sv/tsgm_chain.sv =====
// ----------------------------------------------------------------------------
// tsgm_chain
// Row of sorted cells for one price, with selection of the middle pair.
// ----------------------------------------------------------------------------
module tsgm_chain (
  input  logic                  clk_i,
  input  tsgm_pkg::chain_ctrl_t ctrl_i,
  input  tsgm_pkg::price_t      val_i,
  input  tsgm_pkg::idx_t        lo_idx_i,
  input  tsgm_pkg::idx_t        hi_idx_i,
  output tsgm_pkg::price_t      lo_o,
  output tsgm_pkg::price_t      hi_o
);

  logic             gt   [tsgm_pkg::MAX_GROUP];
  tsgm_pkg::price_t vals [tsgm_pkg::MAX_GROUP];

  for (genvar i = 0; i < tsgm_pkg::MAX_GROUP; i++) begin : g_cell
    logic             left_gt;
    tsgm_pkg::price_t left_val;

    if (i == 0) begin : g_first
      assign left_gt  = 1'b0;
      assign left_val = '0;
    end else begin : g_next
      assign left_gt  = gt[i-1];
      assign left_val = vals[i-1];
    end

    tsgm_cell u_cell (
      .clk_i     (clk_i),
      .idx_i     (tsgm_pkg::IDX_W'(i)),
      .ctrl_i    (ctrl_i),
      .val_i     (val_i),
      .left_gt_i (left_gt),
      .left_val_i(left_val),
      .gt_o      (gt[i]),
      .val_o     (vals[i])
    );
  end

  // One-hot select of the two middle entries.
  always_comb begin
    lo_o = '0;
    hi_o = '0;
    for (int unsigned i = 0; i < tsgm_pkg::MAX_GROUP; i++) begin
      if (lo_idx_i == tsgm_pkg::IDX_W'(i)) lo_o = lo_o | vals[i];
      if (hi_idx_i == tsgm_pkg::IDX_W'(i)) hi_o = hi_o | vals[i];
    end
  end

endmodule

// ===== sv/timestamp_group_median_merge.sv =====
// ----------------------------------------------------------------------------
// timestamp_group_median_merge
// Merge runs of quotes with equal date and time into one median quote.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_item_i) carries quotes or an
//   end marker. Output channel (out_valid_o / out_stall_i / out_item_o)
//   carries one merged quote per closed group. A transfer happens at a clock
//   edge with valid high and stall low.
//   A quote that joins or opens a group drops its bid and offer into place
//   in two rows of sorted cells. A quote that closes a group (new timestamp or
//   end marker) first has the middle pair picked from the cells and
//   registered; then, in the median step, the average and the output
//   register load, together with the opening of the next group for a new
//   timestamp. The merged quote is shown from the output register once the
//   median step loads it, when the output is free.
//   Throughput: one quote per cycle inside a group; a closing item stalls the
//   input through the median step; the shared sorted cell rows set this, as
//   a closed group must be read before the next one is written.
//   Reset: groups empty, no result pending, no output valid.
//   Receiver stall: the output register holds its result; a closing item
//   then waits in the median step and input stall stays high.
//   Quotes beyond MAX_GROUP in one group are dropped and flagged.
// ----------------------------------------------------------------------------
module timestamp_group_median_merge (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  tsgm_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output tsgm_pkg::out_item_t out_item_o
);

  localparam int unsigned PB1 = tsgm_pkg::PRICE_BITS;

  tsgm_pkg::tsgm_state_e state_q, state_d;

  // Group bookkeeping.
  tsgm_pkg::cnt_t                  cnt_q, cnt_d;
  logic                            drop_q, drop_d;
  logic [tsgm_pkg::DATE_W-1:0]     date_q, date_d;
  logic [tsgm_pkg::TIME_W-1:0]     time_q, time_d;
  logic [tsgm_pkg::SYM_W-1:0]      sym_q, sym_d;
  logic [tsgm_pkg::MODE_W-1:0]     mode_q, mode_d;

  // Closing item waiting for the median step.
  tsgm_pkg::in_item_t pend_q, pend_d;

  // Registered middle pairs.
  tsgm_pkg::price_t bid_lo_q, bid_hi_q, off_lo_q, off_hi_q;
  tsgm_pkg::price_t bid_lo, bid_hi, off_lo, off_hi;

  // Output register.
  logic                out_valid_q, out_valid_d;
  tsgm_pkg::out_item_t out_q, out_d;

  // Decode.
  logic                  acc;
  logic                  empty;
  logic                  same_ts;
  logic                  full;
  logic                  emit_req;
  logic                  out_load;
  tsgm_pkg::chain_ctrl_t ctrl;
  tsgm_pkg::price_t      ins_bid, ins_off;
  tsgm_pkg::idx_t        lo_idx, hi_idx;
  logic [PB1:0]          bid_sum, off_sum;

  assign acc     = in_valid_i && (state_q == tsgm_pkg::ST_IDLE);
  assign empty   = (cnt_q == '0);
  assign same_ts = (in_item_i.quote_date == date_q) && (in_item_i.time_of_day == time_q);
  assign full    = (cnt_q >= tsgm_pkg::CNT_W'(tsgm_pkg::MAX_GROUP));
  assign emit_req = acc && !empty && (in_item_i.end_marker || !same_ts);
  assign out_load = (state_q == tsgm_pkg::ST_MEDIAN) && (!out_valid_q || !out_stall_i);

  // Middle pair: equal indexes for an odd count.
  assign lo_idx = tsgm_pkg::IDX_W'((cnt_q - tsgm_pkg::CNT_W'(1)) >> 1);
  assign hi_idx = tsgm_pkg::IDX_W'(cnt_q >> 1);

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      tsgm_pkg::ST_IDLE:   if (emit_req) state_d = tsgm_pkg::ST_MEDIAN;
      tsgm_pkg::ST_MEDIAN: if (out_load) state_d = tsgm_pkg::ST_IDLE;
      default:             state_d = tsgm_pkg::ST_IDLE;
    endcase
  end

  // Outputs of the state machine: stall and chain control.
  always_comb begin
    in_stall_o = 1'b1;
    ctrl.ins   = 1'b0;
    ctrl.count = cnt_q;
    ins_bid    = in_item_i.bid_price;
    ins_off    = in_item_i.offer_price;
    unique case (state_q)
      tsgm_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        if (acc && !in_item_i.end_marker) begin
          if (empty) begin
            ctrl.ins   = 1'b1;
            ctrl.count = '0;
          end else if (same_ts && !full) begin
            ctrl.ins = 1'b1;
          end
        end
      end
      tsgm_pkg::ST_MEDIAN: begin
        ins_bid    = pend_q.bid_price;
        ins_off    = pend_q.offer_price;
        ctrl.count = '0;
        ctrl.ins   = out_load && !pend_q.end_marker;
      end
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
  end

  tsgm_chain u_bids (
    .clk_i   (clk_i),
    .ctrl_i  (ctrl),
    .val_i   (ins_bid),
    .lo_idx_i(lo_idx),
    .hi_idx_i(hi_idx),
    .lo_o    (bid_lo),
    .hi_o    (bid_hi)
  );

  tsgm_chain u_offers (
    .clk_i   (clk_i),
    .ctrl_i  (ctrl),
    .val_i   (ins_off),
    .lo_idx_i(lo_idx),
    .hi_idx_i(hi_idx),
    .lo_o    (off_lo),
    .hi_o    (off_hi)
  );

  // Truncating average of the middle pair; exact with the carry bit.
  assign bid_sum = {1'b0, bid_lo_q} + {1'b0, bid_hi_q};
  assign off_sum = {1'b0, off_lo_q} + {1'b0, off_hi_q};

  // Group state and output register.
  always_comb begin
    cnt_d       = cnt_q;
    drop_d      = drop_q;
    date_d      = date_q;
    time_d      = time_q;
    sym_d       = sym_q;
    mode_d      = mode_q;
    pend_d      = pend_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;

    if (acc && !in_item_i.end_marker && empty) begin
      // Open a group from an empty store.
      cnt_d  = tsgm_pkg::CNT_W'(1);
      drop_d = 1'b0;
      date_d = in_item_i.quote_date;
      time_d = in_item_i.time_of_day;
      sym_d  = in_item_i.symbol_code;
      mode_d = in_item_i.quote_mode;
    end else if (acc && !in_item_i.end_marker && same_ts) begin
      if (full) begin
        drop_d = 1'b1;
      end else begin
        cnt_d  = cnt_q + tsgm_pkg::CNT_W'(1);
        sym_d  = in_item_i.symbol_code;
        mode_d = in_item_i.quote_mode;
      end
    end

    if (emit_req) begin
      pend_d = in_item_i;
    end

    if (out_load) begin
      out_valid_d           = 1'b1;
      out_d.out_symbol      = sym_q;
      out_d.out_date        = date_q;
      out_d.out_time        = time_q;
      out_d.median_bid      = bid_sum[PB1:1];
      out_d.median_offer    = off_sum[PB1:1];
      out_d.out_mode        = mode_q;
      out_d.group_count     = tsgm_pkg::GCNT_W'(cnt_q);
      out_d.overflow_flag   = drop_q;
      drop_d                = 1'b0;
      if (pend_q.end_marker) begin
        cnt_d = '0;
      end else begin
        // Open the next group from the held closing quote.
        cnt_d  = tsgm_pkg::CNT_W'(1);
        date_d = pend_q.quote_date;
        time_d = pend_q.time_of_day;
        sym_d  = pend_q.symbol_code;
        mode_d = pend_q.quote_mode;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tsgm_pkg::ST_IDLE;
      cnt_q       <= '0;
      drop_q      <= 1'b0;
      date_q      <= '0;
      time_q      <= '0;
      sym_q       <= '0;
      mode_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      drop_q      <= drop_d;
      date_q      <= date_d;
      time_q      <= time_d;
      sym_q       <= sym_d;
      mode_q      <= mode_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_q <= pend_d;
    out_q  <= out_d;
    if (emit_req) begin
      bid_lo_q <= bid_lo;
      bid_hi_q <= bid_hi;
      off_lo_q <= off_lo;
      off_hi_q <= off_hi;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // Group size never exceeds the store depth.
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= tsgm_pkg::CNT_W'(tsgm_pkg::MAX_GROUP))
    else $error("group count above store depth");

  // A result appears only after a median step.
  a_out_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == tsgm_pkg::ST_MEDIAN))
    else $error("result without median step");

  // The median step always closes a nonempty group.
  a_med_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == tsgm_pkg::ST_MEDIAN |-> cnt_q != '0)
    else $error("median step on empty group");

  // Sorted rows give an ordered middle pair.
  a_med_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == tsgm_pkg::ST_MEDIAN |-> (bid_lo_q <= bid_hi_q) && (off_lo_q <= off_hi_q))
    else $error("middle pair out of order");

endmodule

// ===== bench/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the timestamp group median merge block. Quotes go
// in over the valid/stall channel and a scoreboard rebuilds each group: it
// keeps sorted bid and offer rows, computes the medians and checks every
// merged quote, field by field, in order. A short directed run covers the
// corner cases. Random groups with random idling on both sides follow, plus
// one long receiver hold-off that backs the block up.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD      = 8;
  localparam int ROW_BID         = 0;
  localparam int ROW_OFFER       = 1;
  localparam int MAX_PAUSE       = 17;
  localparam int QUOTE_TARGET    = 800;
  localparam int HOLD_OFF_AT     = 40;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int DRAIN_CYCLES    = 20;
  localparam int MAX_REPORTS     = 10;

  // Scoreboard: tracks the open group and queues the merged quotes it owes.
  class median_board;
    tsgm_pkg::price_t            store [2][tsgm_pkg::MAX_GROUP];
    int unsigned                 held;
    logic [tsgm_pkg::DATE_W-1:0] cur_date;
    logic [tsgm_pkg::TIME_W-1:0] cur_time;
    logic [tsgm_pkg::SYM_W-1:0]  cur_symbol;
    logic [tsgm_pkg::MODE_W-1:0] cur_mode;
    logic                        dropped;
    tsgm_pkg::out_item_t         merged_q[$];
    int unsigned                 mismatches;
    int unsigned                 checked;

    function new();
      held       = 0;
      cur_date   = '0;
      cur_time   = '0;
      cur_symbol = '0;
      cur_mode   = '0;
      dropped    = 1'b0;
      mismatches = 0;
      checked    = 0;
    endfunction

    // Shift larger entries up by one and drop the price into the gap.
    function void put_sorted(int row, tsgm_pkg::price_t v);
      int i = held;
      while (i > 0 && store[row][i-1] > v) begin
        store[row][i] = store[row][i-1];
        i--;
      end
      store[row][i] = v;
    endfunction

    // Middle entry, or the truncated mean of the middle pair.
    function tsgm_pkg::price_t median(int row);
      logic [tsgm_pkg::PRICE_BITS:0] pair_sum;
      if (held % 2 == 1) return store[row][held/2];
      pair_sum = {1'b0, store[row][held/2-1]} + {1'b0, store[row][held/2]};
      return pair_sum[tsgm_pkg::PRICE_BITS:1];
    endfunction

    function void close_group();
      tsgm_pkg::out_item_t m;
      m.out_symbol    = cur_symbol;
      m.out_date      = cur_date;
      m.out_time      = cur_time;
      m.median_bid    = median(ROW_BID);
      m.median_offer  = median(ROW_OFFER);
      m.out_mode      = cur_mode;
      m.group_count   = tsgm_pkg::GCNT_W'(held);
      m.overflow_flag = dropped;
      merged_q.insert(merged_q.size(), m);
      held    = 0;
      dropped = 1'b0;
    endfunction

    function void open_group(tsgm_pkg::in_item_t q);
      store[ROW_BID][0]   = q.bid_price;
      store[ROW_OFFER][0] = q.offer_price;
      held       = 1;
      cur_date   = q.quote_date;
      cur_time   = q.time_of_day;
      cur_symbol = q.symbol_code;
      cur_mode   = q.quote_mode;
      dropped    = 1'b0;
    endfunction

    // Fold one accepted input transfer into the group state.
    function void note_quote(tsgm_pkg::in_item_t q);
      if (q.end_marker) begin
        if (held != 0) close_group();
      end else if (held == 0) begin
        open_group(q);
      end else if (q.quote_date == cur_date && q.time_of_day == cur_time) begin
        if (held >= tsgm_pkg::MAX_GROUP) begin
          dropped = 1'b1;
        end else begin
          put_sorted(ROW_BID, q.bid_price);
          put_sorted(ROW_OFFER, q.offer_price);
          held++;
          cur_symbol = q.symbol_code;
          cur_mode   = q.quote_mode;
        end
      end else begin
        close_group();
        open_group(q);
      end
    endfunction

    function void compare_field(string field, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("merged quote %0d, %s: expected %0h, got %0h", checked, field, want, got);
      end
    endfunction

    // Check one output transfer against the oldest owed merged quote.
    function void check_merged(tsgm_pkg::out_item_t got);
      tsgm_pkg::out_item_t want;
      if (merged_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("merged quote %0d arrived with none owed: %h", checked, got);
        checked++;
        return;
      end
      want = merged_q.pop_front();
      compare_field("out_symbol", 64'(want.out_symbol), 64'(got.out_symbol));
      compare_field("out_date", 64'(want.out_date), 64'(got.out_date));
      compare_field("out_time", 64'(want.out_time), 64'(got.out_time));
      compare_field("median_bid", 64'(want.median_bid), 64'(got.median_bid));
      compare_field("median_offer", 64'(want.median_offer), 64'(got.median_offer));
      compare_field("out_mode", 64'(want.out_mode), 64'(got.out_mode));
      compare_field("group_count", 64'(want.group_count), 64'(got.group_count));
      compare_field("overflow_flag", 64'(want.overflow_flag), 64'(got.overflow_flag));
      checked++;
    endfunction
  endclass

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_stall;
  tsgm_pkg::in_item_t  in_item   = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  tsgm_pkg::out_item_t out_item;

  median_board board;
  bit          send_burst = 1'b0;
  bit          recv_burst = 1'b0;
  bit          hold_off   = 1'b0;
  int unsigned taken      = 0;

  timestamp_group_median_merge dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item)
  );

  always #(CLK_PERIOD/2) clk = ~clk;

  // Draw an idle length; now and then flip into or out of a no-idle stretch.
  function automatic int draw_pause(inout bit burst);
    if ($urandom_range(0, 24) == 0) burst = !burst;
    return burst ? 0 : $urandom_range(0, MAX_PAUSE);
  endfunction

  // Favor the ends of the price range so duplicates and carries show up.
  function automatic tsgm_pkg::price_t draw_price();
    case ($urandom_range(0, 3))
      0:       return tsgm_pkg::price_t'($urandom_range(0, 15));
      1:       return '1 - tsgm_pkg::price_t'($urandom_range(0, 15));
      default: return tsgm_pkg::price_t'($urandom);
    endcase
  endfunction

  function automatic tsgm_pkg::in_item_t quote(logic [tsgm_pkg::SYM_W-1:0] sym,
                                               logic [tsgm_pkg::DATE_W-1:0] d,
                                               logic [tsgm_pkg::TIME_W-1:0] t,
                                               tsgm_pkg::price_t bid,
                                               tsgm_pkg::price_t offer,
                                               logic [tsgm_pkg::MODE_W-1:0] mode);
    tsgm_pkg::in_item_t q;
    q.end_marker  = 1'b0;
    q.symbol_code = sym;
    q.quote_date  = d;
    q.time_of_day = t;
    q.bid_price   = bid;
    q.offer_price = offer;
    q.quote_mode  = mode;
    return q;
  endfunction

  function automatic tsgm_pkg::in_item_t random_quote(logic [tsgm_pkg::DATE_W-1:0] d,
                                                      logic [tsgm_pkg::TIME_W-1:0] t);
    return quote(tsgm_pkg::SYM_W'($urandom), d, t, draw_price(), draw_price(),
                 tsgm_pkg::MODE_W'($urandom));
  endfunction

  // End marker with random junk in the ignored fields.
  function automatic tsgm_pkg::in_item_t end_mark();
    tsgm_pkg::in_item_t q;
    q = random_quote(tsgm_pkg::DATE_W'($urandom), tsgm_pkg::TIME_W'($urandom));
    q.end_marker = 1'b1;
    return q;
  endfunction

  // Idle a drawn number of cycles, then hold the item until the block takes it.
  task automatic send_item(tsgm_pkg::in_item_t q);
    int gap;
    gap = hold_off ? 0 : draw_pause(send_burst);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= q;
    do @(posedge clk); while (in_stall);
    board.note_quote(q);
  endtask

  // Stall a drawn number of cycles, then wait for one output transfer.
  task automatic take_merged();
    int hold;
    hold = draw_pause(recv_burst);
    if (hold > 0) begin
      out_stall <= 1'b1;
      repeat (hold) @(posedge clk);
    end
    out_stall <= 1'b0;
    do @(posedge clk); while (!out_valid);
    board.check_merged(out_item);
    taken++;
  endtask

  // Receiver: once, hold off long enough that the block backs up and stalls
  // its input while the sender keeps offering back to back.
  task automatic drain_results();
    forever begin
      if (taken == HOLD_OFF_AT) begin
        hold_off  = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_off  = 1'b0;
      end
      take_merged();
    end
  endtask

  task automatic run_directed();
    int i;
    // End marker with nothing open: no output.
    send_item(end_mark());
    // Lone quote, all ones but a zero offer, closed by zeros but an all-ones offer: pass-through.
    send_item(quote('1, '1, '1, '1, '0, '1));
    send_item(quote('0, '0, '0, '0, '1, '0));
    // Grow that group to two: middle pair at opposite price extremes, and at top.
    send_item(quote(16'h5a5a, '0, '0, '1, '1, 8'ha5));
    // Odd count, then even count with a duplicated offer.
    send_item(quote(16'h0101, '0, '0, 32'd1, 32'd3, 8'h11));
    send_item(quote(16'h0202, '0, '0, 32'd2, 32'd3, 8'h22));
    // Flush, then a second marker finds the group empty.
    send_item(end_mark());
    send_item(end_mark());
    // Time alone changes, then date alone changes: each closes the group.
    send_item(quote(16'h1234, 27'd700, 27'd900, 32'd50, 32'd60, 8'h01));
    send_item(quote(16'h1235, 27'd700, 27'd901, 32'd51, 32'd61, 8'h02));
    send_item(quote(16'h1236, 27'd701, 27'd901, 32'd52, 32'd62, 8'h03));
    // Descending prices above the open group's one: each insert lands second in the row.
    for (i = 0; i < 5; i++)
      send_item(quote(tsgm_pkg::SYM_W'(16'h2000 + i), 27'd701, 27'd901,
                      tsgm_pkg::price_t'(1000 - 100 * i),
                      tsgm_pkg::price_t'(5000 - i), tsgm_pkg::MODE_W'(i)));
    send_item(end_mark());
  endtask

  task automatic run_random();
    int sent     = 0;
    int group_no = 0;
    int size;
    logic [tsgm_pkg::DATE_W-1:0] d;
    logic [tsgm_pkg::TIME_W-1:0] t;
    d = tsgm_pkg::DATE_W'($urandom);
    t = tsgm_pkg::TIME_W'($urandom);
    while (sent < QUOTE_TARGET) begin
      // Mostly short groups; a few overflow, exactly full and one short of full.
      case (group_no % 60)
        5:       size = $urandom_range(tsgm_pkg::MAX_GROUP + 1, tsgm_pkg::MAX_GROUP + 8);
        25:      size = tsgm_pkg::MAX_GROUP;
        45:      size = tsgm_pkg::MAX_GROUP - 1;
        default: size = $urandom_range(1, 8);
      endcase
      case ($urandom_range(0, 9))
        0:       t = t + 1'b1;
        1:       d = d + 1'b1;
        2:       ;  // keep the timestamp: merges into the open group, if one is open
        default: begin
          d = tsgm_pkg::DATE_W'($urandom);
          t = tsgm_pkg::TIME_W'($urandom);
        end
      endcase
      repeat (size) begin
        send_item(random_quote(d, t));
        sent++;
      end
      if ($urandom_range(0, 5) == 0) send_item(end_mark());
      if ($urandom_range(0, 19) == 0) send_item(end_mark());
      group_no++;
    end
  endtask

  initial begin
    board = new();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    fork
      drain_results();
    join_none
    run_directed();
    run_random();
    // Flush the last open group and stop offering.
    send_item(end_mark());
    in_valid <= 1'b0;
    while (board.merged_q.size() != 0) @(posedge clk);
    // Let any stray output show up before judging.
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.mismatches == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

  // Timeout guard well beyond the slowest legal run.
  initial begin
    #2ms;
    $display("testbench failed");
    $finish;
  end

endmodule
